>>> hw/rtl/dnsqp_pkg.sv
// Shared types and constants for the DNS question parser.
package dnsqp_pkg;

   localparam int MaxNameDefault = 128;
   localparam int HeaderLast     = 11;
   localparam int FlagsPos       = 2;
   localparam int CountHiPos     = 4;
   localparam int CountLoPos     = 5;
   localparam int TailBytes      = 4;
   localparam logic [7:0] DotChar = 8'h2e;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SHORT = 3'd1,
      ST_NOTQ  = 3'd2,
      ST_COUNT = 3'd3,
      ST_TRUNC = 3'd4,
      ST_LONG  = 3'd5
   } status_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] name_char;
      logic       done_res;
      status_type status;
      logic [15:0] query_type;
      logic [15:0] query_class;
      logic [6:0] name_length;
   } result_type;

endpackage

>>> hw/rtl/dns_question_parser.sv
// DNS question parser: header check, label walk and question result per message.
//
// Usage: a DNS message enters one byte per beat on the req_ channel, header
// first, with req_tlast on its final byte. Each name character (and a dot
// before every label after the first) leaves as a beat on the rsp_ channel
// with rsp_tuser high. The final byte always yields one beat with rsp_tlast
// high that carries the status and, when the status is ok, the name length,
// type and class. Bytes after the question yield nothing.
// Throughput: one byte per cycle sustained while the receiver keeps up; the parse
// state advances in a single combinational step per byte from the input to the result register.
// A two-entry output queue (result register plus skid register) decouples
// the sides: when the receiver stalls, one more result is absorbed and
// req_tready falls only while both entries are full.
// After the final byte the parser returns to its reset state, ready for the
// next message. Synchronous reset clears the parse state and empties the
// output queue.
module dns_question_parser #(
   parameter int MAX_NAME = dnsqp_pkg::MaxNameDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // packet_byte[7:0]
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // name_char[7:0], status[10:8], query_type[26:11], query_class[42:27],
   // name_length[49:43], zero[55:50]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,   // char_valid
   output logic        rsp_tlast    // done_res
);
   import dnsqp_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LEN,
      PH_DATA,
      PH_TAIL,
      PH_IDLE
   } phase_type;

   localparam logic [8:0] MaxName9 = 9'(MAX_NAME);
   localparam logic [7:0] MaxName8 = 8'(MAX_NAME);

   phase_type  parse_phase_ff, parse_phase_in;
   logic [3:0] header_position_ff, header_position_in;
   logic [7:0] label_remaining_ff, label_remaining_in;
   logic [7:0] chars_so_far_ff, chars_so_far_in;
   logic       seen_label_ff, seen_label_in;
   logic [15:0] question_count_ff, question_count_in;
   logic       response_flag_ff, response_flag_in;
   logic [2:0] tail_count_ff, tail_count_in;
   logic [15:0] type_word_ff, type_word_in;
   logic [15:0] class_word_ff, class_word_in;
   status_type pending_error_ff, pending_error_in;

   result_type out_ff, out_in, skid_ff, skid_in, res;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic       accept, pop, push, emit, dot_block;
   logic [7:0] ch;
   status_type fin_status;
   logic [7:0] label_dec;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign label_dec  = label_remaining_ff - 8'd1;

   always_comb begin
      parse_phase_in     = parse_phase_ff;
      header_position_in = header_position_ff;
      label_remaining_in = label_remaining_ff;
      chars_so_far_in    = chars_so_far_ff;
      seen_label_in      = seen_label_ff;
      question_count_in  = question_count_ff;
      response_flag_in   = response_flag_ff;
      tail_count_in      = tail_count_ff;
      type_word_in       = type_word_ff;
      class_word_in      = class_word_ff;
      pending_error_in   = pending_error_ff;
      emit               = 1'b0;
      ch                 = 8'd0;
      dot_block          = 1'b0;
      unique case (parse_phase_ff)
         PH_HEADER: begin
            if (header_position_ff == 4'(FlagsPos)) begin
               response_flag_in = req_tdata[7];
            end else if (header_position_ff == 4'(CountHiPos)) begin
               question_count_in = {req_tdata, 8'd0};
            end else if (header_position_ff == 4'(CountLoPos)) begin
               question_count_in = {question_count_ff[15:8], req_tdata};
            end
            if (header_position_ff >= 4'(HeaderLast)) begin
               if (response_flag_ff) begin
                  pending_error_in = ST_NOTQ;
                  parse_phase_in   = PH_IDLE;
               end else if (question_count_ff != 16'd1) begin
                  pending_error_in = ST_COUNT;
                  parse_phase_in   = PH_IDLE;
               end else begin
                  parse_phase_in = PH_LEN;
               end
            end else begin
               header_position_in = header_position_ff + 4'd1;
            end
         end
         PH_LEN: begin
            if (req_tdata == 8'd0) begin
               parse_phase_in = PH_TAIL;
               tail_count_in  = 3'd0;
            end else begin
               if (seen_label_ff) begin
                  if (chars_so_far_ff >= MaxName8) begin
                     pending_error_in = ST_LONG;
                     parse_phase_in   = PH_IDLE;
                     dot_block        = 1'b1;
                  end else begin
                     chars_so_far_in = chars_so_far_ff + 8'd1;
                     emit            = 1'b1;
                     ch              = DotChar;
                  end
               end
               if (!dot_block) begin
                  seen_label_in      = 1'b1;
                  label_remaining_in = req_tdata;
                  parse_phase_in     = PH_DATA;
                  if ({1'b0, chars_so_far_in} + {1'b0, req_tdata} >= MaxName9) begin
                     pending_error_in = ST_LONG;
                     emit             = 1'b0;
                  end
               end
            end
         end
         PH_DATA: begin
            if (pending_error_ff == ST_OK) begin
               emit            = 1'b1;
               ch              = req_tdata;
               chars_so_far_in = chars_so_far_ff + 8'd1;
            end
            label_remaining_in = label_dec;
            if (label_dec == 8'd0) begin
               parse_phase_in = (pending_error_ff != ST_OK) ? PH_IDLE : PH_LEN;
            end
         end
         PH_TAIL: begin
            if (tail_count_ff < 3'd2) begin
               type_word_in = {type_word_ff[7:0], req_tdata};
            end else begin
               class_word_in = {class_word_ff[7:0], req_tdata};
            end
            tail_count_in = tail_count_ff + 3'd1;
            if (tail_count_in >= 3'(TailBytes)) begin
               parse_phase_in = PH_IDLE;
            end
         end
         default: begin
         end
      endcase

      priority if (parse_phase_ff == PH_HEADER) begin
         fin_status = ST_SHORT;
      end else if (parse_phase_in == PH_IDLE) begin
         fin_status = pending_error_in;
      end else begin
         fin_status = ST_TRUNC;
      end

      res = '0;
      if (req_tlast) begin
         res.done_res = 1'b1;
         res.status   = fin_status;
         if (fin_status == ST_OK) begin
            res.query_type  = type_word_in;
            res.query_class = class_word_in;
            res.name_length = (chars_so_far_in > 8'd127) ? 7'd127 : chars_so_far_in[6:0];
         end
         parse_phase_in     = PH_HEADER;
         header_position_in = 4'd0;
         label_remaining_in = 8'd0;
         chars_so_far_in    = 8'd0;
         seen_label_in      = 1'b0;
         question_count_in  = 16'd0;
         response_flag_in   = 1'b0;
         tail_count_in      = 3'd0;
         type_word_in       = 16'd0;
         class_word_in      = 16'd0;
         pending_error_in   = ST_OK;
      end else begin
         res.char_valid = emit;
         res.name_char  = emit ? ch : 8'd0;
      end
      push = accept && (req_tlast || emit);
   end

   // two-entry output queue; push never meets a full skid since tready gates it
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
            if (push) begin
               skid_in       = res;
               skid_valid_in = 1'b1;
            end
         end else begin
            out_in       = res;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_phase_ff     <= PH_HEADER;
         header_position_ff <= 4'd0;
         label_remaining_ff <= 8'd0;
         chars_so_far_ff    <= 8'd0;
         seen_label_ff      <= 1'b0;
         question_count_ff  <= 16'd0;
         response_flag_ff   <= 1'b0;
         tail_count_ff      <= 3'd0;
         type_word_ff       <= 16'd0;
         class_word_ff      <= 16'd0;
         pending_error_ff   <= ST_OK;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            parse_phase_ff     <= parse_phase_in;
            header_position_ff <= header_position_in;
            label_remaining_ff <= label_remaining_in;
            chars_so_far_ff    <= chars_so_far_in;
            seen_label_ff      <= seen_label_in;
            question_count_ff  <= question_count_in;
            response_flag_ff   <= response_flag_in;
            tail_count_ff      <= tail_count_in;
            type_word_ff       <= type_word_in;
            class_word_ff      <= class_word_in;
            pending_error_ff   <= pending_error_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.char_valid;
   assign rsp_tlast  = out_ff.done_res;
   assign rsp_tdata  = {6'd0, out_ff.name_length, out_ff.query_class, out_ff.query_type,
                        out_ff.status, out_ff.name_char};

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> parse_phase_ff == PH_HEADER && header_position_ff == 4'd0)
      else $error("parser did not restart after final byte");

   a_char_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_ff.char_valid && out_ff.done_res))
      else $error("character and final result in one beat");

   a_err_no_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.status != ST_OK |-> out_ff.name_length == 7'd0)
      else $error("name length reported with error status");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      parse_phase_ff == PH_DATA |-> label_remaining_ff != 8'd0)
      else $error("label data phase with nothing left");

endmodule
